// ===== rtl/crd_pkg.sv =====
// shared types and constants for the rle row decoder
`timescale 1ns / 1ps
package crd_pkg;

   // code byte layout
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned NIB_W    = 4;
   localparam int unsigned NIB_MASK = 'hf;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXELS_PER_ROW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_CEL   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_COLOR    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR         = 8'd3;

   // queue depth
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // classified code byte
   typedef struct packed {
      logic             row_end;
      logic [NIB_W-1:0] color;
      logic [NIB_W-1:0] length;
   } item_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [7:0]       pixels_per_row;
      logic [7:0]       rows_per_cel;
      logic [NIB_W-1:0] transparent_color;
      logic             mirror_enable;
   } cfg_type;

   // one run descriptor
   typedef struct packed {
      logic [7:0]       run_row;
      logic [7:0]       run_start;
      logic [7:0]       run_length;
      logic [NIB_W-1:0] run_color;
      logic             is_fill;
      logic             row_last;
      logic             cel_last;
      logic             was_clipped;
      logic             was_ignored;
   } result_type;

endpackage

// ===== rtl/cel_rle_row_decoder.sv =====
// top level of the sprite cel run-length row decoder
//
//  channel  direction  handshake        payload
//  req      in         valid / stall    code_byte
//  rsp      out        valid / stall    run_row .. was_ignored
//  csr      in         valid / ready    index, data
//
// one code byte in and one run descriptor out per cycle while rsp is not
// stalled; the back end computes each byte's row/column update combinationally.
// a req transfer is written to a queue entry and then to the output register
// before rsp valid rises.
// synchronous reset clears position, queue and valid flags; config regs reset to 0.
// rsp stall fills the queue and then raises req stall; csr is always ready.
`timescale 1ns / 1ps
module cel_rle_row_decoder
   import crd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CODE_W-1:0]    req_code_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_run_row,
   output logic [7:0]           rsp_run_start,
   output logic [7:0]           rsp_run_length,
   output logic [NIB_W-1:0]     rsp_run_color,
   output logic                 rsp_is_fill,
   output logic                 rsp_row_last,
   output logic                 rsp_cel_last,
   output logic                 rsp_was_clipped,
   output logic                 rsp_was_ignored,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   cfg_type    cfg_ff, cfg_in;
   item_type   front_item;
   item_type   queue_item;
   logic       queue_full;
   logic       queue_not_empty;
   logic       queue_pop;
   logic       req_xfer;
   result_type result;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign req_xfer  = req_valid && !queue_full;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXELS_PER_ROW: cfg_in.pixels_per_row    = csr_data;
            CSR_ROWS_PER_CEL:   cfg_in.rows_per_cel      = csr_data;
            CSR_TRANS_COLOR:    cfg_in.transparent_color = csr_data[NIB_W-1:0];
            CSR_MIRROR:         cfg_in.mirror_enable     = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crd_front u_front (
      .code_byte (req_code_byte),
      .item      (front_item)
   );

   crd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   crd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (queue_not_empty),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   // result fields to ports
   assign rsp_run_row     = result.run_row;
   assign rsp_run_start   = result.run_start;
   assign rsp_run_length  = result.run_length;
   assign rsp_run_color   = result.run_color;
   assign rsp_is_fill     = result.is_fill;
   assign rsp_row_last    = result.row_last;
   assign rsp_cel_last    = result.cel_last;
   assign rsp_was_clipped = result.was_clipped;
   assign rsp_was_ignored = result.was_ignored;

endmodule

// ===== rtl/crd_front.sv =====
// front end: splits a code byte into run or row terminator
`timescale 1ns / 1ps
module crd_front
   import crd_pkg::*;
(
   input  logic [CODE_W-1:0] code_byte,
   output item_type          item
);

   // zero ends the row, else color in high nibble and length in low nibble
   always_comb begin
      item.row_end = (code_byte == '0);
      item.color   = code_byte[CODE_W-1:NIB_W];
      item.length  = code_byte[NIB_W-1:0] & NIB_W'(NIB_MASK);
   end

endmodule

// ===== rtl/crd_queue.sv =====
// short queue of classified items between front and back end
`timescale 1ns / 1ps
module crd_queue
   import crd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_item
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/crd_back.sv =====
// back end: tracks row and column, builds run descriptors
`timescale 1ns / 1ps
module crd_back
   import crd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic [7:0] column_ff, column_in;
   logic [7:0] row_ff, row_in;
   logic       complete_ff, complete_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   logic       ignore;
   logic [7:0] start;
   logic [7:0] left;
   logic [7:0] run_len;
   logic [7:0] run_end;
   logic [7:0] row_next;

   // take an item when the output slot is free or being emptied
   assign item_pop  = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = result_ff;

   // decode against current position
   always_comb begin
      ignore = (cfg.pixels_per_row == '0) || (cfg.rows_per_cel == '0) || complete_ff
               || (row_ff >= cfg.rows_per_cel);
      start    = (column_ff < cfg.pixels_per_row) ? column_ff : cfg.pixels_per_row;
      left     = cfg.pixels_per_row - start;
      row_next = row_ff + 8'd1;

      column_in   = column_ff;
      row_in      = row_ff;
      complete_in = complete_ff;
      result_in   = '0;

      if (item.row_end) begin
         run_len = left;
      end else if ({4'd0, item.length} > left) begin
         run_len = left;
      end else begin
         run_len = {4'd0, item.length};
      end
      run_end = start + run_len;

      if (ignore) begin
         result_in.was_ignored = 1'b1;
      end else begin
         result_in.run_row    = row_ff;
         result_in.run_start  = cfg.mirror_enable ? (cfg.pixels_per_row - run_end) : start;
         result_in.run_length = run_len;
         if (item.row_end) begin
            result_in.run_color = cfg.transparent_color;
            result_in.is_fill   = 1'b1;
            result_in.row_last  = 1'b1;
            result_in.cel_last  = (row_next == cfg.rows_per_cel);
            column_in   = '0;
            row_in      = row_next;
            complete_in = (row_next == cfg.rows_per_cel);
         end else begin
            result_in.run_color   = item.color;
            result_in.was_clipped = ({4'd0, item.length} > left);
            column_in = run_end;
         end
      end
   end

   // output slot valid
   always_comb begin
      priority if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            column_ff   <= column_in;
            row_ff      <= row_in;
            complete_ff <= complete_in;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (item_pop) begin
         result_ff <= result_in;
      end
   end

endmodule
